/* src/csa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int ADDRESS_BITS = 20;
    localparam int OWNER_BITS   = 8;
    localparam int COMPACT_MIN  = 3;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_COMPACT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_OWNER = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_DECIDE,
        CMD_PREV,
        CMD_NEXT,
        CMD_CPASS,
        CMD_CTAIL
    } t_dp_cmd;

    typedef struct packed {
        logic is_req;
        logic is_rel;
        logic is_cmp;
        logic few;
        logic last;
        logic stop;
        logic found;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE,
        S_PREV,
        S_NEXT,
        S_CPASS,
        S_CTAIL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/contiguous_segment_allocator_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Segment allocator over an ordered table of up to MAX_SEGMENTS contiguous
// segments. Issue a word with start while busy is low; busy stays high until
// the result, which is shown for exactly one cycle with o_valid and cannot be
// held off, so sample it then. The table is walked one entry per cycle through
// a single read port. A request, or a release that finds no reserved segment
// of its owner, scans up to segment_count entries and then decides; a release
// that frees a segment then merges with each neighbour, previous then next.
// Compact packs the reserved segments down in one pass over every entry and
// then writes any gathered free space as one tail segment, or skips both when
// the table holds under three segments. A write of i_cfg_wdata resets the
// table to one free segment; write only while idle.
module contiguous_segment_allocator_core
    import csa_pkg::*;
#(
    parameter int MAX_SEGMENTS = csa_pkg::MAX_SEGMENTS,
    parameter int ADDRESS_BITS = csa_pkg::ADDRESS_BITS,
    parameter int OWNER_BITS   = csa_pkg::OWNER_BITS
)(
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [ADDRESS_BITS:0]               i_cfg_wdata,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [1:0]                          i_op,
    input  wire  [OWNER_BITS-1:0]               i_owner_id,
    input  wire  [ADDRESS_BITS:0]               i_request_size,
    input  wire  [1:0]                          i_fit_mode,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic [ADDRESS_BITS-1:0]             o_start_address,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0]   o_segment_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    csa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    csa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .OWNER_BITS   (OWNER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_op),
        .i_owner_id      (i_owner_id),
        .i_request_size  (i_request_size),
        .i_fit_mode      (i_fit_mode),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_start_address (o_start_address),
        .o_segment_count (o_segment_count)
    );

endmodule

`default_nettype wire

/* src/csa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module csa_ctrl
    import csa_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy,
    output logic     o_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_req || i_stat.is_rel) begin
                    n_state = S_SCAN;
                end else if (i_stat.is_cmp && !i_stat.few) begin
                    n_state = S_CPASS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_stat.last || i_stat.stop) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd   = CMD_DECIDE;
                n_state = (i_stat.is_rel && i_stat.found) ? S_PREV : S_DONE;
            end
            S_PREV: begin
                o_cmd   = CMD_PREV;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                o_cmd   = CMD_NEXT;
                n_state = S_DONE;
            end
            S_CPASS: begin
                o_cmd = CMD_CPASS;
                if (i_stat.last) begin
                    n_state = S_CTAIL;
                end
            end
            S_CTAIL: begin
                o_cmd   = CMD_CTAIL;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("not idle after result");

    a_load_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_LOAD) |-> !busy) else $error("load while busy");

endmodule

`default_nettype wire

/* src/csa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module csa_dp
    import csa_pkg::*;
#(
    parameter int MAX_SEGMENTS = csa_pkg::MAX_SEGMENTS,
    parameter int ADDRESS_BITS = csa_pkg::ADDRESS_BITS,
    parameter int OWNER_BITS   = csa_pkg::OWNER_BITS,
    localparam int TW = $clog2(MAX_SEGMENTS + 1),
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int SW = ADDRESS_BITS + 1
)(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [SW-1:0]           i_cfg_wdata,
    input  wire  [1:0]              i_op,
    input  wire  [OWNER_BITS-1:0]   i_owner_id,
    input  wire  [SW-1:0]           i_request_size,
    input  wire  [1:0]              i_fit_mode,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output logic [1:0]              o_status,
    output logic [ADDRESS_BITS-1:0] o_start_address,
    output logic [TW-1:0]           o_segment_count
);

    localparam logic [SW-1:0] SPAN = SW'(1) << ADDRESS_BITS;

    logic [ADDRESS_BITS-1:0] r_start [MAX_SEGMENTS];
    logic [SW-1:0]           r_size  [MAX_SEGMENTS];
    logic [OWNER_BITS-1:0]   r_owner [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] r_res;
    logic [TW-1:0]           r_total;
    logic [IW-1:0]           r_idx, r_k;
    logic [TW-1:0]           r_w;
    logic                    r_found;
    logic [SW-1:0]           r_cs, r_acc, r_next, r_spare, r_req;
    logic [ADDRESS_BITS-1:0] r_cst, r_addr;
    logic [1:0]              r_op, r_mode;
    logic [OWNER_BITS-1:0]   r_own;
    t_status                 r_status;

    logic [ADDRESS_BITS-1:0] rd_start;
    logic [SW-1:0]           rd_size;
    logic [OWNER_BITS-1:0]   rd_own;
    logic                    rd_res;
    logic [SW-1:0]           cfg_size;
    logic                    is_req, is_rel, is_cmp, is_best, is_worst;
    logic                    fits, take, hit;
    logic [IW-1:0]           kp1, km1;
    logic [TW-1:0]           idx_t1, k_t1, k_t2;
    logic [SW-1:0]           merged;

    assign rd_start = r_start[r_idx];
    assign rd_size  = r_size[r_idx];
    assign rd_own   = r_owner[r_idx];
    assign rd_res   = r_res[r_idx];

    // clamp the managed size into 1 .. 2^ADDRESS_BITS
    assign cfg_size = (i_cfg_wdata == '0) ? SW'(1)
                    : ((i_cfg_wdata > SPAN) ? SPAN : i_cfg_wdata);

    assign is_req   = (r_op == OP_REQUEST);
    assign is_rel   = (r_op == OP_RELEASE);
    assign is_cmp   = (r_op == OP_COMPACT);
    assign is_best  = (r_mode == FIT_BEST);
    assign is_worst = (r_mode == FIT_WORST);

    assign fits = !rd_res && (rd_size >= r_req);
    assign take = fits && (!r_found || (is_best  ? (rd_size <= r_cs)
                                      : (is_worst ? (rd_size >= r_cs) : 1'b0)));
    assign hit  = rd_res && (rd_own == r_own);

    assign kp1    = r_k + 1'b1;
    assign km1    = r_k - 1'b1;
    assign idx_t1 = TW'(r_idx) + 1'b1;
    assign k_t1   = TW'(r_k) + 1'b1;
    assign k_t2   = TW'(r_k) + TW'(2);
    assign merged = r_acc + rd_size;

    always_comb begin
        o_stat.is_req = is_req;
        o_stat.is_rel = is_rel;
        o_stat.is_cmp = is_cmp;
        o_stat.few    = (r_total < TW'(COMPACT_MIN));
        o_stat.last   = (idx_t1 == r_total);
        o_stat.stop   = (is_req && !is_best && !is_worst && fits) || (is_rel && hit);
        o_stat.found  = r_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_res      <= '0;
            r_total    <= TW'(1);
            r_start[0] <= '0;
            r_size[0]  <= i_rst_n ? cfg_size : SPAN;
        end else begin
            case (i_cmd)
                CMD_LOAD: begin
                    r_op     <= i_op;
                    r_own    <= i_owner_id;
                    r_req    <= i_request_size;
                    r_mode   <= i_fit_mode;
                    r_idx    <= '0;
                    r_found  <= 1'b0;
                    r_w      <= '0;
                    r_next   <= '0;
                    r_spare  <= '0;
                    r_status <= ST_OK;
                    r_addr   <= '0;
                end
                CMD_SCAN: begin
                    if ((is_req && take) || (is_rel && hit && !r_found)) begin
                        r_found <= 1'b1;
                        r_k     <= r_idx;
                        r_cs    <= rd_size;
                        r_cst   <= rd_start;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                CMD_DECIDE: begin
                    if (is_rel) begin
                        if (!r_found) begin
                            r_status <= ST_NO_OWNER;
                        end else begin
                            r_res[r_k] <= 1'b0;
                            r_acc      <= r_cs;
                            r_idx      <= km1;
                        end
                    end else if (r_req == '0 || !r_found) begin
                        r_status <= ST_NO_FIT;
                    end else if (r_cs == r_req) begin
                        r_res[r_k]   <= 1'b1;
                        r_owner[r_k] <= r_own;
                        r_addr       <= r_cst;
                    end else if (r_total >= TW'(MAX_SEGMENTS)) begin
                        r_status <= ST_FULL;
                    end else begin
                        // open a slot above the fit, reserve the low part
                        for (int i = 1; i < MAX_SEGMENTS; i++) begin
                            if (IW'(i) > kp1) begin
                                r_start[i] <= r_start[i-1];
                                r_size[i]  <= r_size[i-1];
                                r_res[i]   <= r_res[i-1];
                                r_owner[i] <= r_owner[i-1];
                            end
                        end
                        r_size[r_k]   <= r_req;
                        r_res[r_k]    <= 1'b1;
                        r_owner[r_k]  <= r_own;
                        r_start[kp1]  <= r_cst + r_req[ADDRESS_BITS-1:0];
                        r_size[kp1]   <= r_cs - r_req;
                        r_res[kp1]    <= 1'b0;
                        r_owner[kp1]  <= r_owner[r_k];
                        r_total       <= r_total + 1'b1;
                        r_addr        <= r_cst;
                    end
                end
                CMD_PREV: begin
                    if (r_k != '0 && !rd_res) begin
                        r_size[km1] <= merged;
                        r_acc       <= merged;
                        for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
                            if (IW'(i) >= r_k) begin
                                r_start[i] <= r_start[i+1];
                                r_size[i]  <= r_size[i+1];
                                r_res[i]   <= r_res[i+1];
                                r_owner[i] <= r_owner[i+1];
                            end
                        end
                        r_total <= r_total - 1'b1;
                        r_k     <= km1;
                        r_idx   <= r_k;
                    end else begin
                        r_idx <= kp1;
                    end
                end
                CMD_NEXT: begin
                    if (k_t1 < r_total && !rd_res) begin
                        for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
                            if (IW'(i) > r_k) begin
                                r_start[i] <= r_start[i+1];
                                r_size[i]  <= r_size[i+1];
                                r_res[i]   <= r_res[i+1];
                                r_owner[i] <= r_owner[i+1];
                            end
                        end
                        r_size[r_k] <= merged;
                        r_total     <= r_total - 1'b1;
                    end
                end
                CMD_CPASS: begin
                    // pack reserved words down, gather free units
                    if (rd_res) begin
                        r_start[r_w[IW-1:0]] <= r_next[ADDRESS_BITS-1:0];
                        r_size[r_w[IW-1:0]]  <= rd_size;
                        r_res[r_w[IW-1:0]]   <= 1'b1;
                        r_owner[r_w[IW-1:0]] <= rd_own;
                        r_next               <= r_next + rd_size;
                        r_w                  <= r_w + 1'b1;
                    end else begin
                        r_spare <= r_spare + rd_size;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                CMD_CTAIL: begin
                    if (r_spare != '0 && r_w < TW'(MAX_SEGMENTS)) begin
                        r_start[r_w[IW-1:0]] <= r_next[ADDRESS_BITS-1:0];
                        r_size[r_w[IW-1:0]]  <= r_spare;
                        r_res[r_w[IW-1:0]]   <= 1'b0;
                        r_total              <= r_w + 1'b1;
                    end else begin
                        r_total <= r_w;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status        = r_status;
    assign o_start_address = r_addr;
    assign o_segment_count = r_total;

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) && (r_total <= TW'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_pack_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_CPASS) |-> (r_w <= TW'(r_idx)))
        else $error("compact write ahead of read");

    a_merge_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_PREV) |-> (k_t1 <= r_total && k_t2 > TW'(1)))
        else $error("released entry outside table");

endmodule

`default_nettype wire
